// ----- src/svbd_pkg.sv -----
// ----------------------------------------------------------------------------
// svbd_pkg
// Shared types and constants of the Stream VByte decoder.
// ----------------------------------------------------------------------------
package svbd_pkg;

  localparam int DefMaxValues = 4096;
  localparam int ByteW        = 8;
  localparam int ValueW       = 32;
  localparam int PartialW     = 24;
  localparam int GroupW       = 8;
  localparam int TotalW       = 15;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic {
    PhKey,
    PhData
  } phase_e;

endpackage

// ----- src/svbd_key_mem.sv -----
// ----------------------------------------------------------------------------
// svbd_key_mem
// Key byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svbd_key_mem
  import svbd_pkg::*;
#(
  parameter int Depth = DefMaxValues / 4,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  byte_t         wr_data_i,
  input  logic [Aw-1:0] rd_addr_i,
  output byte_t         rd_data_o
);

  byte_t mem_q [Depth];
  byte_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/stream_vbyte_decoder.sv -----
// ----------------------------------------------------------------------------
// stream_vbyte_decoder
// A value is registered in the cycle after its last byte beat. One stream
// byte is taken per cycle unless the output stalls, key and data bytes alike;
// the next key byte is prefetched from the key memory while the current one
// decodes. Reset clears the phase, counters and output valid; key memory
// contents are undefined until a stream writes them. No clearing pass is run.
// ----------------------------------------------------------------------------
module stream_vbyte_decoder
  import svbd_pkg::*;
#(
  parameter int MAX_VALUES = DefMaxValues
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [GroupW-1:0]   cfg_group_count_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  byte_t               stream_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValueW-1:0]   decoded_value_o,
  output logic                last_value_o,
  output logic [TotalW-1:0]   bytes_used_o
);

  localparam int KeyDepth  = MAX_VALUES / 4;
  localparam int KeyAw     = $clog2(KeyDepth);
  localparam int MaxGroups = MAX_VALUES / 32;
  localparam int GrpW      = $clog2(MaxGroups + 1);
  localparam int KidxW     = GrpW + 3;
  localparam int CntW      = GrpW + 5;

  logic [GroupW-1:0]   group_count_q;
  phase_e              phase_q, phase_d;
  logic [KidxW-1:0]    kwr_idx_q, kwr_idx_d;
  logic [CntW-1:0]     vidx_q, vidx_d;
  logic [1:0]          biv_q, biv_d;
  logic [PartialW-1:0] partial_q, partial_d;
  logic [TotalW-1:0]   total_q, total_d;
  byte_t               cur_key_q, cur_key_d;

  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   out_value_q, out_value_d;
  logic                out_last_q, out_last_d;
  logic [TotalW-1:0]   out_bytes_q, out_bytes_d;

  logic [GrpW-1:0]     grp_sat;
  logic [CntW-1:0]     count;
  logic [KidxW-1:0]    keys;
  logic                accept;
  logic                key_wr_en;
  logic [KeyAw-1:0]    rd_addr;
  byte_t               rd_data;
  logic [1:0]          code;
  logic [ValueW-1:0]   assembled;
  logic [KidxW-1:0]    kidx;
  logic [CntW-1:0]     vidx_inc;
  logic                emit;
  logic                out_load;

  assign cfg_ready_o = 1'b1;

  assign grp_sat = (int'(group_count_q) > MaxGroups) ? GrpW'(MaxGroups)
                                                      : GrpW'(group_count_q);
  assign count   = {grp_sat, 5'b0};
  assign keys    = {grp_sat, 3'b0};

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_load   = ~out_valid_q | ~out_stall_i;

  assign kidx     = vidx_q[CntW-1:2];
  assign vidx_inc = vidx_q + CntW'(1);
  assign code     = cur_key_q[{vidx_q[1:0], 1'b0} +: 2];
  assign assembled = {{(ValueW-PartialW){1'b0}}, partial_q}
                   | (ValueW'(stream_byte_i) << {biv_q, 3'b0});

  assign key_wr_en = accept && (count != '0) && (phase_q == PhKey);
  assign rd_addr   = (phase_q == PhData) ? KeyAw'(kidx + KidxW'(1)) : '0;

  svbd_key_mem #(
    .Depth (KeyDepth),
    .Aw    (KeyAw)
  ) u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (KeyAw'(kwr_idx_q)),
    .wr_data_i (stream_byte_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    phase_d     = phase_q;
    kwr_idx_d   = kwr_idx_q;
    vidx_d      = vidx_q;
    biv_d       = biv_q;
    partial_d   = partial_q;
    total_d     = total_q;
    cur_key_d   = cur_key_q;
    emit        = 1'b0;
    out_value_d = assembled;
    out_last_d  = 1'b0;
    out_bytes_d = '0;

    if (accept && (count != '0)) begin
      total_d = total_q + TotalW'(1);
      case (phase_q)
        PhKey: begin
          kwr_idx_d = kwr_idx_q + KidxW'(1);
          if ((kwr_idx_q + KidxW'(1)) >= keys) begin
            phase_d   = PhData;
            kwr_idx_d = '0;
            vidx_d    = '0;
            biv_d     = '0;
            partial_d = '0;
            cur_key_d = rd_data;
          end
        end
        PhData: begin
          if (biv_q < code) begin
            partial_d = assembled[PartialW-1:0];
            biv_d     = biv_q + 2'd1;
          end else begin
            emit      = 1'b1;
            vidx_d    = vidx_inc;
            biv_d     = '0;
            partial_d = '0;
            if (vidx_q[1:0] == 2'd3) begin
              cur_key_d = rd_data;
            end
            if (vidx_inc >= count) begin
              out_last_d  = 1'b1;
              out_bytes_d = total_d;
              phase_d     = PhKey;
              kwr_idx_d   = '0;
              vidx_d      = '0;
              total_d     = '0;
            end
          end
        end
        default: begin
          phase_d = PhKey;
        end
      endcase
    end

    if (cfg_valid_i) begin
      phase_d   = PhKey;
      kwr_idx_d = '0;
      vidx_d    = '0;
      biv_d     = '0;
      partial_d = '0;
      total_d   = '0;
      emit      = 1'b0;
    end

    out_valid_d = out_load ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= '0;
      phase_q       <= PhKey;
      kwr_idx_q     <= '0;
      vidx_q        <= '0;
      biv_q         <= '0;
      partial_q     <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        group_count_q <= cfg_group_count_i;
      end
      phase_q     <= phase_d;
      kwr_idx_q   <= kwr_idx_d;
      vidx_q      <= vidx_d;
      biv_q       <= biv_d;
      partial_q   <= partial_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_key_q <= cur_key_d;
    if (out_load) begin
      out_value_q <= out_value_d;
      out_last_q  <= out_last_d;
      out_bytes_q <= out_bytes_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = out_value_q;
  assign last_value_o    = out_last_q;
  assign bytes_used_o    = out_bytes_q;

endmodule

// ----- tb/stream_vbyte_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// stream_vbyte_decoder_tb
// Self-checking bench for the Stream VByte decoder. A tracker class decodes
// every accepted stream byte alongside the block and queues the values it
// expects; each output beat is compared with the oldest one. Streams are
// well-formed with random keys and data, mixed with ignored bytes, streams
// cut short by a register rewrite, and a saturated stream cut short.
// Both sides idle at random, with a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module stream_vbyte_decoder_tb
  import svbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxGroups   = DefMaxValues / 32;
  localparam int KeyDepth    = DefMaxValues / 4;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 80;
  localparam int IdleLimit   = 2000;
  localparam int RandomBytes = 1050;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic [TotalW-1:0] used;
  } value_beat_t;

  class vbyte_decode_tracker;
    byte_t             key_mem[KeyDepth];
    int unsigned       groups;
    phase_e            phase;
    int unsigned       key_idx;
    int unsigned       val_idx;
    int unsigned       byte_idx;
    logic [PartialW-1:0] partial;
    logic [TotalW-1:0] total;
    value_beat_t       pending_values[$];
    int unsigned       errors;
    int unsigned       values_checked;
    int unsigned       streams_closed;

    function new();
      groups = 0;
      errors = 0;
      values_checked = 0;
      streams_closed = 0;
      restart();
    endfunction

    function void restart();
      phase    = PhKey;
      key_idx  = 0;
      val_idx  = 0;
      byte_idx = 0;
      partial  = '0;
      total    = '0;
    endfunction

    function int unsigned value_count();
      return ((groups > MaxGroups) ? MaxGroups : groups) * 32;
    endfunction

    function void set_groups(logic [GroupW-1:0] g);
      groups = g;
      restart();
    endfunction

    function int unsigned pending();
      return pending_values.size();
    endfunction

    function void note_byte(byte_t b);
      int unsigned       cnt;
      logic [1:0]        code;
      logic [ValueW-1:0] v;
      value_beat_t       r;
      cnt = value_count();
      if (cnt == 0) return;
      total = total + 1'b1;
      if (phase == PhKey) begin
        key_mem[key_idx] = b;
        key_idx++;
        if (key_idx >= cnt / 4) begin
          phase    = PhData;
          key_idx  = 0;
          val_idx  = 0;
          byte_idx = 0;
          partial  = '0;
        end
        return;
      end
      code = key_mem[val_idx / 4][2 * (val_idx % 4) +: 2];
      v = {8'h00, partial} | ({24'h000000, b} << (8 * byte_idx));
      if (byte_idx < code) begin
        partial = v[PartialW-1:0];
        byte_idx++;
        return;
      end
      val_idx++;
      byte_idx = 0;
      partial  = '0;
      r.value  = v;
      if (val_idx >= cnt) begin
        r.last = 1'b1;
        r.used = total;
        restart();
      end else begin
        r.last = 1'b0;
        r.used = '0;
      end
      pending_values.push_back(r);
    endfunction

    function void check_value(logic [ValueW-1:0] value, logic last, logic [TotalW-1:0] used);
      value_beat_t e;
      if (pending_values.size() == 0) begin
        $error("unexpected value beat: decoded_value %h last_value %b bytes_used %0d",
               value, last, used);
        errors++;
        return;
      end
      e = pending_values.pop_front();
      values_checked++;
      if (last === 1'b1) streams_closed++;
      if (value !== e.value) begin
        $error("decoded_value: expected %h, got %h", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_value: expected %b, got %b", e.last, last);
        errors++;
      end
      if (used !== e.used) begin
        $error("bytes_used: expected %0d, got %0d", e.used, used);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [GroupW-1:0]   cfg_group_count_i;
  logic                in_valid_i;
  logic                in_stall_o;
  byte_t               stream_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ValueW-1:0]   decoded_value_o;
  logic                last_value_o;
  logic [TotalW-1:0]   bytes_used_o;

  vbyte_decode_tracker tracker;
  bit                  quiet;
  bit                  hold_req;
  int unsigned         bytes_sent;
  int unsigned         idle_cycles = 0;

  stream_vbyte_decoder i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_group_count_i (cfg_group_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .stream_byte_i     (stream_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .decoded_value_o   (decoded_value_o),
    .last_value_o      (last_value_o),
    .bytes_used_o      (bytes_used_o)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        tracker.check_value(decoded_value_o, last_value_o, bytes_used_o);
        idle_cycles = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        tracker.note_byte(stream_byte_i);
        idle_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.set_groups(cfg_group_count_i);
        idle_cycles = 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("no beat accepted for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned w;
    bit          held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        w    = HoldCycles;
        held = 1'b1;
      end else begin
        w = quiet ? 0 : $urandom_range(0, 5);
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
      @(negedge clk);
    end
  end

  function automatic byte_t rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic drain_input();
    in_valid_i <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_groups(input int unsigned g);
    drain_input();
    cfg_valid_i       <= 1'b1;
    cfg_group_count_i <= GroupW'(g);
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_stream(input int unsigned g, input int unsigned cut,
                            input bit mid_pause, input bit sparse_keys);
    byte_t       beats[$];
    int unsigned n;
    int unsigned code;
    write_groups(g);
    n = (g > MaxGroups) ? MaxGroups : g;
    for (int unsigned i = 0; i < n * 8; i++)
      beats.push_back((sparse_keys && i >= 16) ? 8'h00 : rand_byte());
    for (int unsigned v = 0; v < n * 32; v++) begin
      code = beats[v / 4][2 * (v % 4) +: 2];
      for (int unsigned j = 0; j <= code; j++) beats.push_back(rand_byte());
    end
    if (cut > 0 && cut < beats.size()) beats = beats[0:cut-1];
    for (int unsigned i = 0; i < beats.size(); i++) begin
      if (mid_pause && i == beats.size() / 2) drain_input();
      send_byte(beats[i]);
      if (g > 0) bytes_sent++;
    end
  endtask

  initial begin : stimulus
    byte_t       seed_beats[22];
    int unsigned sel;
    int unsigned g;
    bit          hold_done;
    seed_beats        = '{8'hE4, 8'hFF, 8'h00, 8'h1B, 8'h55, 8'hAA, 8'h80, 8'h01,
                          8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80,
                          8'h01, 8'h00, 8'h00, 8'h80,
                          8'hFF, 8'hFF, 8'hFF, 8'hFF};
    tracker           = new();
    quiet             = 1'b0;
    hold_req          = 1'b0;
    hold_done         = 1'b0;
    bytes_sent        = 0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_group_count_i = '0;
    in_valid_i        = 1'b0;
    stream_byte_i     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    write_groups(0);
    for (int i = 0; i < 4; i++) send_byte(seed_beats[i]);
    write_groups(1);
    foreach (seed_beats[i]) begin
      send_byte(seed_beats[i]);
      bytes_sent++;
    end
    write_groups(128);
    for (int i = 0; i < 3; i++) begin
      send_byte(seed_beats[i]);
      bytes_sent++;
    end

    while (bytes_sent < RandomBytes) begin
      quiet = ($urandom_range(0, 4) == 0);
      sel   = $urandom_range(0, 9);
      if (sel == 0) begin
        run_stream(0, $urandom_range(1, 4), 1'b0, 1'b0);
      end else if (sel == 1) begin
        run_stream($urandom_range(1, 255), $urandom_range(1, 60), 1'b0, 1'b0);
      end else begin
        g = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
        if (!hold_done) begin
          g         = 3;
          quiet     = 1'b1;
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        run_stream(g, 0, $urandom_range(0, 3) == 0, 1'b0);
      end
    end

    quiet = 1'b0;
    run_stream(255, $urandom_range(1, 60), 1'b0, 1'b1);
    drain_input();

    $display("Sent %0d stream bytes; %0d values checked, %0d streams closed.",
             bytes_sent, tracker.values_checked, tracker.streams_closed);
    $display("Group counts covered disabled, small, mid-stream rewrites and saturation.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
